### rtl/rtpc_pkg.sv
package rtpc_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORG_Z    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIM = 2'd3;

  // Width of the distance limit register.
  localparam int DIST_LIM_W = 24;

  // Microprogram sequencing.
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } state_e;

  // Multiplier operand A: a narrow difference or a chunk of a wide result.
  typedef enum logic [3:0] {
    A_E1X, A_E1Y, A_SX, A_SY,
    A_ULO, A_UHI, A_VLO, A_VHI, A_DLO, A_DHI
  } a_sel_e;

  // Multiplier operand B.
  typedef enum logic [2:0] {
    B_E2X, B_E2Y, B_E1X, B_E1Y, B_E1Z, B_E2Z, B_SZ, B_MAX
  } b_sel_e;

  // Stored wide value added straight into the accumulator.
  typedef enum logic {
    R_DET, R_U
  } reg_sel_e;

  typedef enum logic [1:0] {
    ST_NONE, ST_DET, ST_U, ST_V
  } store_e;

  // Sign tests on the accumulator, corrected by the sign of the determinant.
  typedef enum logic [2:0] {
    CK_NONE, CK_GE, CK_LE, CK_GT, CK_LT
  } chk_e;

  typedef struct packed {
    a_sel_e   a_sel;
    b_sel_e   b_sel;
    logic     from_reg;
    reg_sel_e reg_sel;
    logic     shift;
    logic     neg;
    logic     clr;
    store_e   store;
    chk_e     chk;
    logic     fin;
  } step_ctl_t;

  // One accumulator pass per step; the accumulator value after each check
  // step is the quantity named in the comment.
  function automatic step_ctl_t step_ctl(input logic [STEP_W-1:0] idx);
    step_ctl_t c;
    case (idx)
      // det = e1y*e2x - e1x*e2y
      5'd0:  c = '{A_E1Y, B_E2X, 1'b0, R_DET, 1'b0, 1'b0, 1'b1, ST_NONE, CK_NONE, 1'b0};
      5'd1:  c = '{A_E1X, B_E2Y, 1'b0, R_DET, 1'b0, 1'b1, 1'b0, ST_DET,  CK_NONE, 1'b0};
      // U = sy*e2x - sx*e2y, then U - det
      5'd2:  c = '{A_SY,  B_E2X, 1'b0, R_DET, 1'b0, 1'b0, 1'b1, ST_NONE, CK_NONE, 1'b0};
      5'd3:  c = '{A_SX,  B_E2Y, 1'b0, R_DET, 1'b0, 1'b1, 1'b0, ST_U,    CK_GE,   1'b0};
      5'd4:  c = '{A_SX,  B_E2Y, 1'b1, R_DET, 1'b0, 1'b1, 1'b0, ST_NONE, CK_LE,   1'b0};
      // V = sx*e1y - sy*e1x, then U + V - det
      5'd5:  c = '{A_SX,  B_E1Y, 1'b0, R_DET, 1'b0, 1'b0, 1'b1, ST_NONE, CK_NONE, 1'b0};
      5'd6:  c = '{A_SY,  B_E1X, 1'b0, R_DET, 1'b0, 1'b1, 1'b0, ST_V,    CK_GE,   1'b0};
      5'd7:  c = '{A_SY,  B_E1X, 1'b1, R_U,   1'b0, 1'b0, 1'b0, ST_NONE, CK_NONE, 1'b0};
      5'd8:  c = '{A_SY,  B_E1X, 1'b1, R_DET, 1'b0, 1'b1, 1'b0, ST_NONE, CK_LE,   1'b0};
      // T = U*e1z + V*e2z - det*sz, wide operands split in two chunks
      5'd9:  c = '{A_ULO, B_E1Z, 1'b0, R_DET, 1'b0, 1'b0, 1'b1, ST_NONE, CK_NONE, 1'b0};
      5'd10: c = '{A_UHI, B_E1Z, 1'b0, R_DET, 1'b1, 1'b0, 1'b0, ST_NONE, CK_NONE, 1'b0};
      5'd11: c = '{A_VLO, B_E2Z, 1'b0, R_DET, 1'b0, 1'b0, 1'b0, ST_NONE, CK_NONE, 1'b0};
      5'd12: c = '{A_VHI, B_E2Z, 1'b0, R_DET, 1'b1, 1'b0, 1'b0, ST_NONE, CK_NONE, 1'b0};
      5'd13: c = '{A_DLO, B_SZ,  1'b0, R_DET, 1'b0, 1'b1, 1'b0, ST_NONE, CK_NONE, 1'b0};
      5'd14: c = '{A_DHI, B_SZ,  1'b0, R_DET, 1'b1, 1'b1, 1'b0, ST_NONE, CK_GT,   1'b0};
      // T - limit*det
      5'd15: c = '{A_DLO, B_MAX, 1'b0, R_DET, 1'b0, 1'b1, 1'b0, ST_NONE, CK_NONE, 1'b0};
      5'd16: c = '{A_DHI, B_MAX, 1'b0, R_DET, 1'b1, 1'b1, 1'b0, ST_NONE, CK_LT,   1'b1};
      default: c = '{A_E1X, B_E2X, 1'b0, R_DET, 1'b0, 1'b0, 1'b0, ST_NONE, CK_NONE, 1'b0};
    endcase
    return c;
  endfunction

endpackage

### rtl/ray_triangle_parity_counter.sv
// Ray/triangle parity counter. A ray leaves the configured origin straight up
// (+z) and the mesh is streamed through the block one triangle per request.
// Each triangle gets an exact fixed-point ray/triangle intersection test: no
// division, the barycentric and distance bounds are compared after scaling by
// the determinant, and a zero determinant is never a hit. A hit needs the
// distance strictly between zero and the configured distance limit. Every
// triangle returns one result with the hit flag, the saturating running hit
// count, its parity (1 means the origin is inside) and an echo of
// last_triangle; after the last triangle the count is cleared. A triangle
// passes through 17 microprogram steps on the single shared multiplier,
// followed by one accumulate stage and a result-load state that waits for
// the output register to be free; the next triangle is accepted after that.
// A new triangle may be accepted while the previous result still waits on
// the output register. Configuration writes are taken at any time but must
// only be issued while no triangle is in flight; a write takes effect from
// the next triangle.
module ray_triangle_parity_counter #(
  parameter int COORD_WIDTH = 24,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [rtpc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [rtpc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]        v0_x_i,
  input  logic signed [COORD_WIDTH-1:0]        v0_y_i,
  input  logic signed [COORD_WIDTH-1:0]        v0_z_i,
  input  logic signed [COORD_WIDTH-1:0]        v1_x_i,
  input  logic signed [COORD_WIDTH-1:0]        v1_y_i,
  input  logic signed [COORD_WIDTH-1:0]        v1_z_i,
  input  logic signed [COORD_WIDTH-1:0]        v2_x_i,
  input  logic signed [COORD_WIDTH-1:0]        v2_y_i,
  input  logic signed [COORD_WIDTH-1:0]        v2_z_i,
  input  logic                                 last_triangle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 hit_o,
  output logic [COUNT_WIDTH-1:0]               crossings_o,
  output logic                                 inside_res_o,
  output logic                                 last_o
);
  import rtpc_pkg::*;

  // Edge and origin differences need one extra bit.
  localparam int DW = COORD_WIDTH + 1;
  // det, U and V are differences of two products of such differences.
  localparam int XW = 2 * COORD_WIDTH + 2;
  // Wide values are fed to the multiplier as a low and a high chunk.
  localparam int H  = COORD_WIDTH + 1;
  localparam int NA = COORD_WIDTH + 2;
  localparam int NB = (DW > DIST_LIM_W + 1) ? DW : DIST_LIM_W + 1;
  localparam int PW = NA + NB;
  // The accumulator holds T and limit*det exactly, plus margin.
  localparam int TW = 3 * COORD_WIDTH + 4;
  localparam int MW = 2 * COORD_WIDTH + DIST_LIM_W + 2;
  localparam int AW = ((TW > MW) ? TW : MW) + 2;

  // Configuration registers.
  logic signed [COORD_WIDTH-1:0] org_x_q, org_y_q, org_z_q;
  logic [DIST_LIM_W-1:0]         maxd_q;

  // Triangle operands, captured as differences on acceptance.
  logic signed [DW-1:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
  logic signed [DW-1:0] sx_q, sy_q, sz_q;
  logic                 last_q;

  // Sequencer.
  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q;
  logic                issue;
  step_ctl_t           ctl_c, ctl_q;
  logic                pv_q;

  // Shared multiplier and accumulator.
  logic signed [NA-1:0] a_op;
  logic signed [NB-1:0] b_op;
  logic signed [PW-1:0] prod_c, prod_q;
  logic signed [AW-1:0] addend, base, sum, acc_q;
  logic signed [XW-1:0] det_q, u_q, v_q;
  logic                 z_c, n_c, s_c, chk_ok, det_nz;
  logic                 ok_q, hit_q;

  // Hit count and result register.
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_new;
  logic                   load;
  logic                   out_valid_q;
  logic                   hit_out_q, inside_q, last_out_q;
  logic [COUNT_WIDTH-1:0] cross_q;

  logic accept;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
      maxd_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORG_X:    org_x_q <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        CFG_ORG_Y:    org_y_q <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        CFG_ORG_Z:    org_z_q <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        CFG_DIST_LIM: maxd_q  <= cfg_data_i[DIST_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Every difference is one narrow subtraction, all done in parallel.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      e1x_q  <= DW'(v1_x_i) - DW'(v0_x_i);
      e1y_q  <= DW'(v1_y_i) - DW'(v0_y_i);
      e1z_q  <= DW'(v1_z_i) - DW'(v0_z_i);
      e2x_q  <= DW'(v2_x_i) - DW'(v0_x_i);
      e2y_q  <= DW'(v2_y_i) - DW'(v0_y_i);
      e2z_q  <= DW'(v2_z_i) - DW'(v0_z_i);
      sx_q   <= DW'(org_x_q) - DW'(v0_x_i);
      sy_q   <= DW'(org_y_q) - DW'(v0_y_i);
      sz_q   <= DW'(org_z_q) - DW'(v0_z_i);
      last_q <= last_triangle_i;
    end
  end

  // The microprogram issues one step per cycle while running.
  assign issue = (state_q == S_RUN) && (step_q <= LAST_STEP);
  assign ctl_c = step_ctl(step_q);

  always_comb begin
    case (ctl_c.a_sel)
      A_E1X:   a_op = NA'(e1x_q);
      A_E1Y:   a_op = NA'(e1y_q);
      A_SX:    a_op = NA'(sx_q);
      A_SY:    a_op = NA'(sy_q);
      A_ULO:   a_op = $signed({1'b0, u_q[H-1:0]});
      A_UHI:   a_op = NA'($signed(u_q[XW-1:H]));
      A_VLO:   a_op = $signed({1'b0, v_q[H-1:0]});
      A_VHI:   a_op = NA'($signed(v_q[XW-1:H]));
      A_DLO:   a_op = $signed({1'b0, det_q[H-1:0]});
      A_DHI:   a_op = NA'($signed(det_q[XW-1:H]));
      default: a_op = '0;
    endcase
  end

  always_comb begin
    case (ctl_c.b_sel)
      B_E2X:   b_op = NB'(e2x_q);
      B_E2Y:   b_op = NB'(e2y_q);
      B_E1X:   b_op = NB'(e1x_q);
      B_E1Y:   b_op = NB'(e1y_q);
      B_E1Z:   b_op = NB'(e1z_q);
      B_E2Z:   b_op = NB'(e2z_q);
      B_SZ:    b_op = NB'(sz_q);
      B_MAX:   b_op = $signed(NB'(maxd_q));
      default: b_op = '0;
    endcase
  end

  assign prod_c = a_op * b_op;

  // Product register: the accumulate of a step happens in the cycle after
  // its multiply, together with the step's control word.
  always_ff @(posedge clk_i) begin
    if (issue) begin
      prod_q <= prod_c;
    end
  end

  // Accumulate stage. The addend is either the registered product (high
  // chunks shifted up by the chunk width) or a stored wide result.
  always_comb begin
    if (ctl_q.from_reg) begin
      addend = (ctl_q.reg_sel == R_DET) ? AW'(det_q) : AW'(u_q);
    end else if (ctl_q.shift) begin
      addend = AW'(prod_q) <<< H;
    end else begin
      addend = AW'(prod_q);
    end
    base = ctl_q.clr ? '0 : acc_q;
    sum  = base + (addend ^ {AW{ctl_q.neg}}) + AW'(ctl_q.neg);
  end

  // The bounds are tested on det-scaled values; a negative determinant
  // flips the sense of every sign test instead of negating the operands.
  assign z_c    = (sum == '0);
  assign n_c    = sum[AW-1];
  assign s_c    = det_q[XW-1];
  assign det_nz = (det_q != '0);

  always_comb begin
    case (ctl_q.chk)
      CK_NONE: chk_ok = 1'b1;
      CK_GE:   chk_ok = z_c || (n_c == s_c);
      CK_LE:   chk_ok = z_c || (n_c != s_c);
      CK_GT:   chk_ok = !z_c && (n_c == s_c);
      CK_LT:   chk_ok = !z_c && (n_c != s_c);
      default: chk_ok = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pv_q) begin
      acc_q <= sum;
      case (ctl_q.store)
        ST_DET:  det_q <= $signed(sum[XW-1:0]);
        ST_U:    u_q   <= $signed(sum[XW-1:0]);
        ST_V:    v_q   <= $signed(sum[XW-1:0]);
        default: ;
      endcase
    end
  end

  // The result register is loaded once the previous result has left.
  assign load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_RUN;
      S_RUN:   if (pv_q && ctl_q.fin) state_d = S_FIN;
      S_FIN:   if (load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      pv_q    <= 1'b0;
      ctl_q   <= step_ctl('0);
      ok_q    <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pv_q    <= issue;
      if (accept) begin
        step_q <= '0;
        ok_q   <= 1'b1;
      end else if (issue) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (issue) begin
        ctl_q <= ctl_c;
      end
      if (pv_q) begin
        ok_q <= ok_q && chk_ok;
        if (ctl_q.fin) begin
          hit_q <= ok_q && chk_ok && det_nz;
        end
      end
    end
  end

  // Saturating count including the current triangle.
  assign cnt_new = cnt_q + COUNT_WIDTH'(hit_q && (cnt_q != '1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        cnt_q       <= last_q ? '0 : cnt_new;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      hit_out_q  <= hit_q;
      cross_q    <= cnt_new;
      inside_q   <= cnt_new[0];
      last_out_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_out_q;
  assign crossings_o  = cross_q;
  assign inside_res_o = inside_q;
  assign last_o       = last_out_q;

`ifndef SYNTHESIS
  // The final accumulate always hands over to the result-load state.
  a_fin_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) && pv_q && ctl_q.fin |=> (state_q == S_FIN))
    else $error("final step did not move to result load");

  // No step may still be in the accumulate stage when a new triangle can enter.
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pv_q)
    else $error("accumulate stage busy while accepting a triangle");

  // A loaded result that is not the last one keeps the count it reported.
  a_count_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !last_q |=> (cnt_q == cross_q))
    else $error("hit count differs from reported crossings");
`endif

endmodule

### verif/ray_triangle_parity_counter_tb.sv
module ray_triangle_parity_counter_tb;
  import rtpc_pkg::*;

  localparam int COORD_W     = 24;
  localparam int CNT_W       = 16;
  localparam int CMIN        = -8388608;
  localparam int CMAX        = 8388607;
  localparam int DIST_MAX    = 16777215;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 125;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 400000;

  // One triangle request. Index 0, 1 and 2 of each array are vertices v0, v1 and v2.
  typedef struct packed {
    logic [2:0][COORD_W-1:0] x;
    logic [2:0][COORD_W-1:0] y;
    logic [2:0][COORD_W-1:0] z;
    logic                    last;
  } tri_t;

  // One result of the block, laid out as its output ports.
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] crossings;
    logic             parity;
    logic             last;
  } crossing_t;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [CFG_IDX_W-1:0]        cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]       cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic signed [COORD_W-1:0]   v0_x_i = '0, v0_y_i = '0, v0_z_i = '0;
  logic signed [COORD_W-1:0]   v1_x_i = '0, v1_y_i = '0, v1_z_i = '0;
  logic signed [COORD_W-1:0]   v2_x_i = '0, v2_y_i = '0, v2_z_i = '0;
  logic                        last_triangle_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic                        hit_o;
  logic [CNT_W-1:0]            crossings_o;
  logic                        inside_res_o;
  logic                        last_o;

  ray_triangle_parity_counter #(
    .COORD_WIDTH(COORD_W),
    .COUNT_WIDTH(CNT_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .v0_x_i         (v0_x_i),
    .v0_y_i         (v0_y_i),
    .v0_z_i         (v0_z_i),
    .v1_x_i         (v1_x_i),
    .v1_y_i         (v1_y_i),
    .v1_z_i         (v1_z_i),
    .v2_x_i         (v2_x_i),
    .v2_y_i         (v2_y_i),
    .v2_z_i         (v2_z_i),
    .last_triangle_i(last_triangle_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .crossings_o    (crossings_o),
    .inside_res_o   (inside_res_o),
    .last_o         (last_o)
  );

  // Triangles waiting to be offered, and results predicted for accepted triangles.
  tri_t      mesh_q[$];
  crossing_t crossing_q[$];

  // Our own copy of the block's registers and running hit count.
  logic signed [COORD_W-1:0] org_x = '0, org_y = '0, org_z = '0;
  logic [DIST_LIM_W-1:0]     dist_lim = '0;
  logic [CNT_W-1:0]          hit_cnt = '0;

  int  mismatch_cnt  = 0;
  int  send_idle_pct = 0;
  int  rx_stall_pct  = 0;
  int  cycle_cnt     = 0;
  logic rx_hold      = 1'b0;
  event hold_ev;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The whole run must finish well within this many cycles; a hang ends here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Exact ray/triangle intersection test against a ray pointing along +z. With
  // that fixed direction every quantity is a small polynomial in the
  // coordinates, so 128-bit signed arithmetic holds all of them without loss.
  // The bounds on u, v and t are compared after scaling by the determinant,
  // which is first made positive by flipping the sign of all four quantities
  // together.
  function automatic crossing_t predict_crossing(tri_t t);
    logic signed [127:0] e1x, e1y, e1z, e2x, e2y, e2z, sx, sy, sz;
    logic signed [127:0] det, uu, vv, tt, maxw;
    logic                hit;
    crossing_t           r;
    e1x  = $signed(t.x[1]) - $signed(t.x[0]);
    e1y  = $signed(t.y[1]) - $signed(t.y[0]);
    e1z  = $signed(t.z[1]) - $signed(t.z[0]);
    e2x  = $signed(t.x[2]) - $signed(t.x[0]);
    e2y  = $signed(t.y[2]) - $signed(t.y[0]);
    e2z  = $signed(t.z[2]) - $signed(t.z[0]);
    sx   = org_x - $signed(t.x[0]);
    sy   = org_y - $signed(t.y[0]);
    sz   = org_z - $signed(t.z[0]);
    det  = e1y * e2x - e1x * e2y;
    uu   = sy * e2x - sx * e2y;
    vv   = sx * e1y - sy * e1x;
    tt   = uu * e1z + vv * e2z - det * sz;
    maxw = {104'd0, dist_lim};
    hit  = 1'b0;
    // A flat (zero area in the xy projection) triangle is never crossed.
    if (det != 0) begin
      if (det < 0) begin
        det = -det;
        uu  = -uu;
        vv  = -vv;
        tt  = -tt;
      end
      // Edges and vertices count as inside; t must be strictly inside (0, max).
      hit = (uu >= 0) && (uu <= det) && (vv >= 0) && (uu + vv <= det) &&
            (tt > 0) && (tt < maxw * det);
    end
    // The count saturates instead of wrapping.
    if (hit && hit_cnt != '1) hit_cnt = hit_cnt + 1'b1;
    r.hit       = hit;
    r.crossings = hit_cnt;
    r.parity    = hit_cnt[0];
    r.last      = t.last;
    // The result of the final triangle still carries the count; clear it after.
    if (t.last) hit_cnt = '0;
    return r;
  endfunction

  // Driver: whenever the input slot is free, offer the next triangle unless
  // this cycle is chosen as idle. Valid and payload hold until accepted.
  always @(posedge clk_i) begin : drive_mesh
    tri_t nxt;
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (mesh_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = mesh_q.pop_front();
        in_valid_i      <= 1'b1;
        v0_x_i          <= nxt.x[0];
        v0_y_i          <= nxt.y[0];
        v0_z_i          <= nxt.z[0];
        v1_x_i          <= nxt.x[1];
        v1_y_i          <= nxt.y[1];
        v1_z_i          <= nxt.z[1];
        v2_x_i          <= nxt.x[2];
        v2_y_i          <= nxt.y[2];
        v2_z_i          <= nxt.z[2];
        last_triangle_i <= nxt.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result side back-pressure: random stalls, or a solid hold-off while
  // rx_hold is set.
  always @(posedge clk_i) begin
    out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  // Long receiver hold-off, counted here so that the sender keeps offering
  // triangles meanwhile and the block has to stall its input.
  always begin
    @(hold_ev);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Monitor: track register writes, predict a result for every accepted
  // triangle (built from the ports, so exactly what the block took), and
  // check every accepted result against the oldest prediction.
  always @(posedge clk_i) begin : watch_ports
    tri_t      seen;
    crossing_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ORG_X:    org_x    = cfg_data_i[COORD_W-1:0];
          CFG_ORG_Y:    org_y    = cfg_data_i[COORD_W-1:0];
          CFG_ORG_Z:    org_z    = cfg_data_i[COORD_W-1:0];
          CFG_DIST_LIM: dist_lim = cfg_data_i[DIST_LIM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        seen.x    = {v2_x_i, v1_x_i, v0_x_i};
        seen.y    = {v2_y_i, v1_y_i, v0_y_i};
        seen.z    = {v2_z_i, v1_z_i, v0_z_i};
        seen.last = last_triangle_i;
        crossing_q.push_back(predict_crossing(seen));
      end
      if (out_valid_o && out_ready_i) begin
        if (crossing_q.size() == 0) begin
          $display("%0t: result with no request pending: hit %0b crossings %0d",
                   $time, hit_o, crossings_o);
          mismatch_cnt++;
        end else begin
          want = crossing_q.pop_front();
          if (hit_o !== want.hit) begin
            $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit_o);
            mismatch_cnt++;
          end
          if (crossings_o !== want.crossings) begin
            $display("%0t: crossings expected %0d actual %0d",
                     $time, want.crossings, crossings_o);
            mismatch_cnt++;
          end
          if (inside_res_o !== want.parity) begin
            $display("%0t: inside_res expected %0b actual %0b",
                     $time, want.parity, inside_res_o);
            mismatch_cnt++;
          end
          if (last_o !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $time, want.last, last_o);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  function automatic void add_triangle(int x0, int y0, int z0, int x1, int y1, int z1,
                                       int x2, int y2, int z2, bit last);
    tri_t t;
    t.x    = {COORD_W'(x2), COORD_W'(x1), COORD_W'(x0)};
    t.y    = {COORD_W'(y2), COORD_W'(y1), COORD_W'(y0)};
    t.z    = {COORD_W'(z2), COORD_W'(z1), COORD_W'(z0)};
    t.last = last;
    mesh_q.push_back(t);
  endfunction

  // Random triangle aimed at the ray. Most are drawn around the origin's
  // xy position so that a fair share is crossed; the plane height is put at,
  // inside or past the distance window, and some get a vertex or an edge
  // exactly on the ray, collapse to zero area, or swap winding. The rest are
  // pure noise over all coordinate bits.
  function automatic void add_random_triangle(int ox, int oy, int oz, int maxd);
    int px[3], py[3], pz[3];
    int s, zb, k, tmp;
    bit tilt;
    s = 1 << $urandom_range(0, 16);
    if ($urandom_range(99) < 12) begin
      for (k = 0; k < 3; k++) begin
        px[k] = $urandom;
        py[k] = $urandom;
        pz[k] = $urandom;
      end
    end else begin
      px[0] = ox - $urandom_range(0, s);
      py[0] = oy - $urandom_range(0, s);
      px[1] = ox + $urandom_range(0, s);
      py[1] = oy - $urandom_range(0, s);
      px[2] = ox + $urandom_range(0, 2 * s) - s;
      py[2] = oy + $urandom_range(0, s);
      case ($urandom_range(5))
        0:       zb = oz;
        1:       zb = oz + maxd;
        2:       zb = oz - $urandom_range(0, s);
        default: zb = oz + $urandom_range(0, maxd + maxd / 4 + 1);
      endcase
      tilt = ($urandom_range(2) == 0);
      for (k = 0; k < 3; k++) pz[k] = tilt ? zb + $urandom_range(0, 2 * s) - s : zb;
      case ($urandom_range(7))
        0: begin
          px[2] = px[1];
          py[2] = py[1];
        end
        1: begin
          k     = $urandom_range(2);
          px[k] = ox;
          py[k] = oy;
        end
        2: begin
          // Mirror v1 through the origin so the ray passes the middle of an edge.
          px[2] = 2 * ox - px[1];
          py[2] = 2 * oy - py[1];
        end
        default: ;
      endcase
      if ($urandom_range(1)) begin
        tmp = px[1]; px[1] = px[2]; px[2] = tmp;
        tmp = py[1]; py[1] = py[2]; py[2] = tmp;
        tmp = pz[1]; pz[1] = pz[2]; pz[2] = tmp;
      end
    end
    add_triangle(px[0], py[0], pz[0], px[1], py[1], pz[1], px[2], py[2], pz[2],
                 $urandom_range(7) == 0);
  endfunction

  // Register write at a rising edge, held until the block takes it. The bits
  // above the register width carry random junk that must be ignored.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= {8'($urandom), 24'(val)};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input int ox, input int oy, input int oz, input int maxd);
    write_reg(CFG_ORG_X, ox);
    write_reg(CFG_ORG_Y, oy);
    write_reg(CFG_ORG_Z, oz);
    write_reg(CFG_DIST_LIM, maxd);
    @(negedge clk_i);
  endtask

  // Returns once every triangle has been accepted and every result has come
  // back. Sampled on the falling edge, after all rising-edge updates.
  task automatic wait_idle();
    while (mesh_q.size() != 0 || in_valid_i || crossing_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin : sequencer
    int ox, oy, oz, maxd, p, i;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers at their reset values: origin zero and a zero distance window,
    // so even a triangle squarely over the origin must not count.
    add_triangle(-10, -10, 500, 10, -10, 500, 0, 10, 500, 1'b0);
    add_triangle(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b1);
    wait_idle();

    ox = 100; oy = -200; oz = -50; maxd = 1000;
    write_all(ox, oy, oz, maxd);
    // Plain crossing, then the same triangle wound the other way.
    add_triangle(ox-10, oy-10, oz+500, ox+10, oy-10, oz+500, ox, oy+10, oz+500, 1'b0);
    add_triangle(ox-10, oy-10, oz+500, ox, oy+10, oz+500, ox+10, oy-10, oz+500, 1'b0);
    // Zero area: two vertices equal, then three on one line.
    add_triangle(ox-10, oy-10, oz+500, ox+10, oy-10, oz+500, ox+10, oy-10, oz+500, 1'b0);
    add_triangle(ox-10, oy-10, oz+500, ox+10, oy-10, oz+400, ox+30, oy-10, oz+300, 1'b0);
    // Plane through the origin, at the window end, just inside it, and below.
    add_triangle(ox-10, oy-10, oz, ox+10, oy-10, oz, ox, oy+10, oz, 1'b0);
    add_triangle(ox-10, oy-10, oz+1000, ox+10, oy-10, oz+1000, ox, oy+10, oz+1000, 1'b0);
    add_triangle(ox-10, oy-10, oz+999, ox+10, oy-10, oz+999, ox, oy+10, oz+999, 1'b0);
    add_triangle(ox-10, oy-10, oz-5, ox+10, oy-10, oz-5, ox, oy+10, oz-5, 1'b0);
    // Ray through a vertex, through the middle of an edge, and just missing it.
    add_triangle(ox, oy, oz+200, ox+10, oy-10, oz+200, ox, oy+10, oz+200, 1'b0);
    add_triangle(ox-10, oy-10, oz+200, ox+10, oy-10, oz+200, ox-10, oy+10, oz+200, 1'b0);
    add_triangle(ox-10, oy-10, oz+200, ox+9, oy-10, oz+200, ox-10, oy+9, oz+200, 1'b0);
    // Off to the side, then a tilted plane closing the mesh.
    add_triangle(ox+40, oy-10, oz+200, ox+60, oy-10, oz+200, ox+50, oy+10, oz+200, 1'b0);
    add_triangle(ox-10, oy-10, oz+100, ox+10, oy-10, oz+300, ox, oy+10, oz+700, 1'b1);
    // The count starts over after the mesh end.
    add_triangle(ox-10, oy-10, oz+500, ox+10, oy-10, oz+500, ox, oy+10, oz+500, 1'b0);
    add_triangle(CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, 1'b1);
    wait_idle();

    // Extreme registers: origin at the most negative corner, widest window.
    // The first triangle sits exactly at the window end, the second one inside.
    write_all(CMIN, CMIN, CMIN, DIST_MAX);
    add_triangle(CMIN, CMIN, CMAX, CMIN+20, CMIN, CMAX, CMIN, CMIN+20, CMAX, 1'b0);
    add_triangle(CMIN, CMIN, CMAX-1, CMIN+20, CMIN, CMAX-1, CMIN, CMIN+20, CMAX-1, 1'b0);
    add_triangle(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1'b1);

    // Random phases, each with its own register setting and an idling pattern.
    for (p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      case (p)
        4: begin
          ox = CMIN; oy = CMAX; oz = CMIN; maxd = DIST_MAX;
        end
        5: begin
          ox = $urandom_range(0, 1 << 21) - (1 << 20);
          oy = $urandom_range(0, 1 << 21) - (1 << 20);
          oz = $urandom_range(0, 1 << 21) - (1 << 20);
          maxd = $urandom_range(0, 16);
        end
        default: begin
          ox = $urandom_range(0, 1 << 21) - (1 << 20);
          oy = $urandom_range(0, 1 << 21) - (1 << 20);
          oz = $urandom_range(0, 1 << 21) - (1 << 20);
          maxd = $urandom_range(1, 1 << $urandom_range(4, 23));
        end
      endcase
      write_all(ox, oy, oz, maxd);
      case (p)
        1:       begin send_idle_pct = 72; rx_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  rx_stall_pct = 72; end
        3, 5:    begin send_idle_pct = 37; rx_stall_pct = 37; end
        default: begin send_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) add_random_triangle(ox, oy, oz, maxd);
      // In the first phase the receiver locks up for a while with a full queue.
      if (p == 0) -> hold_ev;
    end

    wait_idle();
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
    if (crossing_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, crossing_q.size());
      mismatch_cnt++;
    end
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### ray_triangle_parity_counter.f
rtl/rtpc_pkg.sv
rtl/ray_triangle_parity_counter.sv
verif/ray_triangle_parity_counter_tb.sv
